// ===== rtl/grg_pkg.sv =====
// shared types, constants and elaboration-time tables for the gamma ramp generator
`timescale 1ns / 1ps
package grg_pkg;

    localparam int RAMP_ENTRIES = 256;
    localparam int LVL_W        = 8;
    localparam int CH_W         = 2;
    localparam int CFG_W        = 16;
    localparam int OUT_W        = 16;
    localparam int G_W          = 17;   // clamped gamma, 41 .. 65534
    localparam int D_W          = 35;   // log2 difference, Q.32, below 2^35
    localparam int N_W          = D_W + 12;
    localparam int FRAC_W       = 32;
    localparam int Y_W          = 33;   // Q0.32 with room for 1.0
    localparam int GAMMA_MIN    = 41;
    localparam logic [LVL_W+1:0] DENOM = (LVL_W + 2)'(RAMP_ENTRIES - 1);

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_RED   = 2'd1;
    localparam logic [1:0] REG_GREEN = 2'd2;
    localparam logic [1:0] REG_BLUE  = 2'd3;

    typedef logic [D_W-1:0]    t_dtab [0:RAMP_ENTRIES-1];
    typedef logic [FRAC_W-1:0] t_ctab [1:FRAC_W];

    // side info that rides with every item down the pipeline
    typedef struct packed {
        logic              valid;
        logic              forced;
        logic [OUT_W-1:0]  fval;
    } t_side;

    function automatic logic [63:0] log2_q32(input int v);
        logic [63:0] m;
        logic [63:0] frac;
        int          n;
        n = 0;
        for (int b = 1; b < 31; b++) begin
            if ((v >> b) != 0) n = b;
        end
        m = 64'(v) << (31 - n);
        frac = '0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (64'(n) << 32) | frac;
    endfunction

    function automatic t_dtab build_dtab();
        t_dtab       t;
        logic [63:0] top;
        top = log2_q32(RAMP_ENTRIES - 1);
        for (int l = 0; l < RAMP_ENTRIES; l++) begin
            if (l == 0 || l >= RAMP_ENTRIES - 1) t[l] = '0;
            else t[l] = D_W'(top - log2_q32(l));
        end
        return t;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = xin;
        r = '0;
        b = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (b > x) b = b >> 2;
        end
        for (int s = 0; s < 32; s++) begin
            if (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic t_ctab build_ctab();
        t_ctab       t;
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int i = 1; i <= FRAC_W; i++) begin
            c = isqrt64(c << 32);
            t[i] = FRAC_W'(c);
        end
        return t;
    endfunction

    localparam t_dtab DTAB = build_dtab();
    localparam t_ctab CTAB = build_ctab();

endpackage

// ===== rtl/grg_front.sv =====
// input stage: gamma sum and clamp, log difference lookup, special levels
`timescale 1ns / 1ps
module grg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [grg_pkg::CH_W-1:0]        i_channel,
    input  logic [grg_pkg::LVL_W-1:0]       i_level,
    input  logic [grg_pkg::CFG_W-1:0]       i_base,
    input  logic [grg_pkg::CFG_W-1:0]       i_red,
    input  logic [grg_pkg::CFG_W-1:0]       i_green,
    input  logic [grg_pkg::CFG_W-1:0]       i_blue,
    output grg_pkg::t_side                  o_side,
    output logic [grg_pkg::N_W-1:0]         o_num,
    output logic [grg_pkg::G_W-1:0]         o_gamma
);
    logic [grg_pkg::CFG_W-1:0] w_off;
    logic signed [grg_pkg::G_W-1:0] w_sum;
    grg_pkg::t_side n_side, r_side;
    logic [grg_pkg::N_W-1:0] r_num;
    logic [grg_pkg::G_W-1:0] r_gamma, n_gamma;

    function automatic logic signed [grg_pkg::G_W-1:0] G_W_sext(input logic [grg_pkg::CFG_W-1:0] v);
        return {{(grg_pkg::G_W - grg_pkg::CFG_W){v[grg_pkg::CFG_W-1]}}, v};
    endfunction

    always_comb begin
        w_off = i_red;
        n_side.valid  = i_valid;
        n_side.forced = 1'b0;
        n_side.fval   = '0;
        case (i_channel)
            grg_pkg::CH_RED:   w_off = i_red;
            grg_pkg::CH_GREEN: w_off = i_green;
            grg_pkg::CH_BLUE:  w_off = i_blue;
            default: begin
                n_side.forced = 1'b1;
            end
        endcase
        if (!n_side.forced) begin
            if (i_level == '0) begin
                n_side.forced = 1'b1;
            end else if ({2'b00, i_level} >= grg_pkg::DENOM) begin
                n_side.forced = 1'b1;
                n_side.fval   = '1;
            end
        end
        w_sum = G_W_sext(i_base) + G_W_sext(w_off);
        if (w_sum < grg_pkg::G_W'(grg_pkg::GAMMA_MIN)) n_gamma = grg_pkg::G_W'(grg_pkg::GAMMA_MIN);
        else n_gamma = grg_pkg::G_W'(w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= n_side;
        end
        if (i_en) begin
            r_num   <= {grg_pkg::DTAB[i_level], 12'd0};
            r_gamma <= n_gamma;
        end
    end

    assign o_side  = r_side;
    assign o_num   = r_num;
    assign o_gamma = r_gamma;
endmodule

// ===== rtl/grg_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module grg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  grg_pkg::t_side              i_side,
    input  logic [grg_pkg::N_W-1:0]     i_num,
    input  logic [grg_pkg::G_W-1:0]     i_gamma,
    output grg_pkg::t_side              o_side,
    output logic [grg_pkg::N_W-1:0]     o_quot
);
    localparam int S = grg_pkg::N_W;

    grg_pkg::t_side          r_side  [0:S];
    logic [grg_pkg::N_W-1:0] r_num   [0:S];
    logic [grg_pkg::N_W-1:0] r_quot  [0:S];
    logic [grg_pkg::G_W-1:0] r_rem   [0:S];
    logic [grg_pkg::G_W-1:0] r_gamma [0:S];

    always_comb begin
        r_side[0]  = i_side;
        r_num[0]   = i_num;
        r_quot[0]  = '0;
        r_rem[0]   = '0;
        r_gamma[0] = i_gamma;
    end

    for (genvar j = 0; j < S; j++) begin : g_stage
        logic [grg_pkg::G_W:0] w_try;
        logic                  w_ge;
        logic [grg_pkg::G_W:0] w_diff;
        assign w_try  = {r_rem[j], r_num[j][grg_pkg::N_W-1]};
        assign w_ge   = w_try >= {1'b0, r_gamma[j]};
        assign w_diff = w_try - {1'b0, r_gamma[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[j+1] <= '0;
            end else if (i_en) begin
                r_side[j+1] <= r_side[j];
            end
            if (i_en) begin
                r_num[j+1]   <= r_num[j] << 1;
                r_quot[j+1]  <= {r_quot[j][grg_pkg::N_W-2:0], w_ge};
                r_rem[j+1]   <= w_ge ? w_diff[grg_pkg::G_W-1:0] : w_try[grg_pkg::G_W-1:0];
                r_gamma[j+1] <= r_gamma[j];
            end
        end
    end

    assign o_side = r_side[S];
    assign o_quot = r_quot[S];
endmodule

// ===== rtl/grg_exp.sv =====
// exp2 of the negated quotient: one table multiply per fraction bit, then shift and scale
`timescale 1ns / 1ps
module grg_exp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  grg_pkg::t_side              i_side,
    input  logic [grg_pkg::N_W-1:0]     i_t,
    output logic                        o_valid,
    output logic [grg_pkg::OUT_W-1:0]   o_value
);
    localparam int F  = grg_pkg::FRAC_W;
    localparam int KW = grg_pkg::N_W - F;

    grg_pkg::t_side          r_side [0:F];
    logic [grg_pkg::N_W-1:0] r_t    [0:F];
    logic [grg_pkg::Y_W-1:0] r_y    [0:F];

    always_comb begin
        r_side[0] = i_side;
        r_t[0]    = i_t;
        r_y[0]    = grg_pkg::Y_W'(1) << F;
    end

    for (genvar i = 1; i <= F; i++) begin : g_mul
        logic [grg_pkg::Y_W+F-1:0] w_prod;
        assign w_prod = r_y[i-1] * grg_pkg::CTAB[i];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[i] <= '0;
            end else if (i_en) begin
                r_side[i] <= r_side[i-1];
            end
            if (i_en) begin
                r_t[i] <= r_t[i-1];
                r_y[i] <= r_t[i-1][F-i] ? w_prod[grg_pkg::Y_W+F-1:F] : r_y[i-1];
            end
        end
    end

    // integer part shift; anything past 32 drains to zero
    grg_pkg::t_side          r_sh_side;
    logic [grg_pkg::Y_W-1:0] r_sh_y;
    logic [KW-1:0]           w_k;
    assign w_k = r_t[F][grg_pkg::N_W-1:F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_side <= '0;
        end else if (i_en) begin
            r_sh_side <= r_side[F];
        end
        if (i_en) begin
            r_sh_y <= (w_k > KW'(F)) ? '0 : (r_y[F] >> w_k);
        end
    end

    logic [grg_pkg::Y_W+grg_pkg::OUT_W-1:0] w_scaled;
    logic                                   r_valid;
    logic [grg_pkg::OUT_W-1:0]              r_value;
    assign w_scaled = ({r_sh_y, {grg_pkg::OUT_W{1'b0}}})
                    - {{grg_pkg::OUT_W{1'b0}}, r_sh_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_sh_side.valid;
        end
        if (i_en) begin
            r_value <= r_sh_side.forced ? r_sh_side.fval
                     : w_scaled[F+grg_pkg::OUT_W-1:F];
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
endmodule

// ===== rtl/gamma_ramp_generator.sv =====
// gamma ramp generator top level: config registers and pipeline
`timescale 1ns / 1ps
// Per-channel power-law gamma curve, one item per cycle while the output is not stalled.
// Input channel: s_tvalid/s_tready, s_tuser = color channel (0 red, 1 green,
// 2 blue), s_tdata[7:0] = level. Output channel: m_tvalid/m_tready,
// m_tdata = 16-bit ramp entry.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 gamma base, 1 red, 2 green, 3 blue offset, all signed Q4.12).
// Write registers only while no item is in flight.
// The pipeline is one input stage, 47 divider stages (one quotient
// bit each), 32 exp2 multiply stages, one shift stage and the output register.
// Throughput is one item per cycle; the whole pipeline advances together.
// When the receiver stalls with a result held, every stage freezes and
// s_tready drops in the same cycle; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults (base 0, channel offsets 1.0).
module gamma_ramp_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] level
    input  logic [1:0]  s_tuser,    // [1:0] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [15:0] ramp_value
);
    logic [grg_pkg::CFG_W-1:0] r_base, r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= 16'd0;
            r_red   <= 16'd4096;
            r_green <= 16'd4096;
            r_blue  <= 16'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                grg_pkg::REG_BASE:  r_base  <= i_cfg_data;
                grg_pkg::REG_RED:   r_red   <= i_cfg_data;
                grg_pkg::REG_GREEN: r_green <= i_cfg_data;
                grg_pkg::REG_BLUE:  r_blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_en;
    assign w_en     = !m_tvalid || m_tready;
    assign s_tready = w_en;

    grg_pkg::t_side          w_f_side, w_d_side;
    logic [grg_pkg::N_W-1:0] w_num, w_quot;
    logic [grg_pkg::G_W-1:0] w_gamma;

    grg_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(s_tvalid), .i_channel(s_tuser), .i_level(s_tdata),
        .i_base(r_base), .i_red(r_red), .i_green(r_green), .i_blue(r_blue),
        .o_side(w_f_side), .o_num(w_num), .o_gamma(w_gamma)
    );

    grg_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_side(w_f_side), .i_num(w_num), .i_gamma(w_gamma),
        .o_side(w_d_side), .o_quot(w_quot)
    );

    grg_exp u_exp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_side(w_d_side), .i_t(w_quot),
        .o_valid(m_tvalid), .o_value(m_tdata)
    );
endmodule

// ===== rtl/grg_checker.sv =====
// port-level checks for the gamma ramp generator
`timescale 1ns / 1ps
module grg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |=> !$fell(m_tvalid))
        else $error("result dropped during stall");
endmodule

bind gamma_ramp_generator grg_checker u_grg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ===== tb/sv/gamma_ramp_generator_tb.sv =====
// testbench for the gamma ramp generator: table-driven and random levels checked by a predictor
`timescale 1ns / 1ps
module gamma_ramp_generator_tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 90;

    typedef struct {
        logic [1:0] ch;
        logic [7:0] lvl;
        int         want;   // -1: take the predicted value
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] level
    logic [1:0]  s_tuser;    // [1:0] channel
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] ramp_value

    logic [15:0]       gamma_regs [0:3];
    longint unsigned   exp_coef [1:32];
    logic [15:0]       ramp_expected [$];
    int                errors;
    int                idle_cycles;
    int                burst_left;
    int                stall_cnt;

    gamma_ramp_generator dut (.*);

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned xin);
        longint unsigned x, r, b;
        x = xin;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned log2_fix(input int unsigned v);
        longint unsigned m, frac;
        int n;
        n = 0;
        while (n < 31 && (v >> (n + 1)) != 0) n++;
        m = longint'(v) << (31 - n);
        frac = 0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(n) << 32) | frac;
    endfunction

    function automatic logic [15:0] ramp_for(input logic [1:0] ch, input logic [7:0] lvl);
        logic [15:0]     off;
        int              g;
        longint unsigned d, t, y, k;
        case (ch)
            grg_pkg::CH_RED:   off = gamma_regs[grg_pkg::REG_RED];
            grg_pkg::CH_GREEN: off = gamma_regs[grg_pkg::REG_GREEN];
            grg_pkg::CH_BLUE:  off = gamma_regs[grg_pkg::REG_BLUE];
            default:           return 16'd0;
        endcase
        if (lvl == 0) return 16'd0;
        if (lvl >= grg_pkg::RAMP_ENTRIES - 1) return 16'hFFFF;
        g = int'($signed(gamma_regs[grg_pkg::REG_BASE])) + int'($signed(off));
        if (g < grg_pkg::GAMMA_MIN) g = grg_pkg::GAMMA_MIN;
        d = log2_fix(grg_pkg::RAMP_ENTRIES - 1) - log2_fix(lvl);
        t = (d * 4096) / longint'(g);
        k = t >> 32;
        y = 64'h1_0000_0000;
        for (int i = 1; i <= 32; i++) begin
            if ((t >> (32 - i)) & 1) y = (y * exp_coef[i]) >> 32;
        end
        y = (k > 32) ? 0 : (y >> k);
        return 16'((y * 65535) >> 32);
    endfunction

    // sender: bursts with random gaps; expectation pushed when the item is taken
    task automatic send_level(input logic [1:0] ch, input logic [7:0] lvl, input int want);
        logic taken;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= lvl;
        do begin
            @(negedge i_clk);
            taken = s_tready;
            @(posedge i_clk);
        end while (!taken);
        ramp_expected.push_back(want >= 0 ? 16'(want) : ramp_for(ch, lvl));
    endtask

    task automatic drain_and_write(input logic [15:0] vals [0:3]);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (ramp_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 2'(r);
            i_cfg_data <= vals[r];
            gamma_regs[r] = vals[r];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver stalls in changing modes: never, half the time, mostly
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        case ((stall_cnt >> 8) % 3)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(negedge i_clk) begin
        if (m_tvalid && m_tready) begin
            if (ramp_expected.size() == 0) begin
                $display("%0t: unexpected ramp_value %0d", $time, m_tdata);
                errors++;
            end else begin
                if (m_tdata !== ramp_expected[0]) begin
                    $display("%0t: ramp_value expected %0d actual %0d",
                             $time, ramp_expected[0], m_tdata);
                    errors++;
                end
                void'(ramp_expected.pop_front());
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_row            rows [15];
        logic [15:0]     cfg [0:3];
        longint unsigned c;
        int              sel;
        logic [7:0]      lvl;
        logic [1:0]      ch;

        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        stall_cnt = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = grg_pkg::REG_BASE;
        i_cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = grg_pkg::CH_RED;
        m_tready = 1'b0;
        gamma_regs[grg_pkg::REG_BASE]  = 16'd0;
        gamma_regs[grg_pkg::REG_RED]   = 16'd4096;
        gamma_regs[grg_pkg::REG_GREEN] = 16'd4096;
        gamma_regs[grg_pkg::REG_BLUE]  = 16'd4096;
        c = 64'd1 << 31;
        for (int i = 1; i <= 32; i++) begin
            c = int_sqrt(c << 32);
            exp_coef[i] = c;
        end

        rows = '{
            '{grg_pkg::CH_RED, 8'd0, 0},      '{grg_pkg::CH_GREEN, 8'd0, 0},
            '{grg_pkg::CH_BLUE, 8'd0, 0},
            '{grg_pkg::CH_RED, 8'd255, 65535}, '{grg_pkg::CH_GREEN, 8'd255, 65535},
            '{grg_pkg::CH_BLUE, 8'd255, 65535},
            '{2'd3, 8'd0, 0},       '{2'd3, 8'd255, 0},       '{2'd3, 8'd128, 0},
            '{grg_pkg::CH_RED, 8'd1, -1},     '{grg_pkg::CH_RED, 8'd254, -1},
            '{grg_pkg::CH_GREEN, 8'd128, -1}, '{grg_pkg::CH_BLUE, 8'd170, -1},
            '{grg_pkg::CH_GREEN, 8'd85, -1},  '{grg_pkg::CH_BLUE, 8'd1, -1}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) send_level(rows[r].ch, rows[r].lvl, rows[r].want);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: cfg = '{16'h8000, 16'h8000, 16'h8000, 16'h8000};  // clamp at minimum
                1: cfg = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
                2: cfg = '{16'd0, 16'd41, 16'd40, 16'd42};           // around the clamp
                3: cfg = '{16'hF000, 16'd8192, 16'd6144, 16'd2048};
                4: cfg = '{16'd0, 16'd4096, 16'd4096, 16'd4096};
                default: for (int r = 0; r < 4; r++) cfg[r] = 16'($urandom);
            endcase
            drain_and_write(cfg);
            for (int n = 0; n < 215; n++) begin
                sel = $urandom_range(0, 19);
                ch  = (sel == 0) ? 2'd3 : 2'($urandom_range(0, 2));
                if (sel == 1)      lvl = 8'd0;
                else if (sel == 2) lvl = 8'd255;
                else if (sel == 3) lvl = 8'd254;
                else if (sel == 4) lvl = 8'd1;
                else               lvl = 8'($urandom);
                send_level(ch, lvl, -1);
            end
        end

        s_tvalid <= 1'b0;
        while (ramp_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/grg_pkg.sv
rtl/grg_front.sv
rtl/grg_div.sv
rtl/grg_exp.sv
rtl/gamma_ramp_generator.sv
rtl/grg_checker.sv
tb/sv/gamma_ramp_generator_tb.sv
